/* src/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold after the antecedent, delayed by the dly argument.
`define ASSERT_DELAYED(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("assertion failed");

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`endif

/* src/u8d_pkg.sv */
// Types and constants of the UTF-8 sequence decoder.
// Used by the classify stage, the assemble stage and the top level.
package u8d_pkg;

   localparam logic [7:0] LEAD6_MIN  = 8'hFC;
   localparam logic [7:0] LEAD5_MIN  = 8'hF8;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD2_MIN  = 8'hC0;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [2:0] AVAIL_MAX  = 3'd6;
   localparam int         NUM_CONT   = 5;
   localparam int         CP_WIDTH   = 31;

   // Result of the first stage: lead class and per-byte continuation data.
   typedef struct packed {
      logic       empty;
      logic [2:0] avail;
      logic [2:0] extra;
      logic [7:0] lead_payload;
      logic [4:0] cont_ok;
      logic [29:0] cont_bits;
   } class_type;

   // Result of the second stage before zeroing on error.
   typedef struct packed {
      logic        empty;
      logic        err;
      logic [2:0]  used;
      logic [30:0] value;
   } asm_type;

endpackage

/* src/utf8_sequence_decoder.sv */
// Top level of the UTF-8 sequence decoder: three register stages.
// Depends on u8d_pkg, u8d_classify and u8d_assemble.
//
// Decodes one UTF-8 sequence (1 to 6 byte form) per beat. A window is taken
// on every cycle in which start is high and busy is low; busy is high only
// during reset. Each result passes the classification, assembly and output
// registers in that order and appears for one cycle, marked by rsp_valid.
// The receiver must take every result as shown.
module utf8_sequence_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_byte_0,
   input  logic [7:0]  req_byte_1,
   input  logic [7:0]  req_byte_2,
   input  logic [7:0]  req_byte_3,
   input  logic [7:0]  req_byte_4,
   input  logic [7:0]  req_byte_5,
   input  logic [2:0]  req_bytes_available,
   output logic        rsp_valid,
   output logic [30:0] rsp_code_point,
   output logic [2:0]  rsp_bytes_used,
   output logic        rsp_error
);

   logic                cls_valid;
   u8d_pkg::class_type  cls_data;
   logic                asm_valid;
   u8d_pkg::asm_type    asm_data;

   logic                valid_ff;
   logic [30:0]         code_point_ff;
   logic [30:0]         code_point_in;
   logic [2:0]          bytes_used_ff;
   logic [2:0]          bytes_used_in;
   logic                error_ff;

   assign busy = reset;

   u8d_classify u_classify (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (start && !busy),
      .byte_0          (req_byte_0),
      .byte_1          (req_byte_1),
      .byte_2          (req_byte_2),
      .byte_3          (req_byte_3),
      .byte_4          (req_byte_4),
      .byte_5          (req_byte_5),
      .bytes_available (req_bytes_available),
      .out_valid       (cls_valid),
      .out_class       (cls_data)
   );

   u8d_assemble u_assemble (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cls_valid),
      .in_class  (cls_data),
      .out_valid (asm_valid),
      .out_asm   (asm_data)
   );

   // An empty window and an error both report zero value and zero length.
   always_comb begin
      if (asm_data.empty || asm_data.err) begin
         code_point_in = '0;
         bytes_used_in = 3'd0;
      end else begin
         code_point_in = asm_data.value;
         bytes_used_in = asm_data.used;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= asm_valid;
      end
   end

   always_ff @(posedge clock) begin
      code_point_ff <= code_point_in;
      bytes_used_ff <= bytes_used_in;
      error_ff      <= asm_data.err;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_code_point = code_point_ff;
   assign rsp_bytes_used = bytes_used_ff;
   assign rsp_error      = error_ff;

endmodule

/* src/u8d_classify.sv */
// First stage of the decoder: classifies the lead byte and checks the
// continuation prefixes of the window. Depends on u8d_pkg.
module u8d_classify (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           byte_0,
   input  logic [7:0]           byte_1,
   input  logic [7:0]           byte_2,
   input  logic [7:0]           byte_3,
   input  logic [7:0]           byte_4,
   input  logic [7:0]           byte_5,
   input  logic [2:0]           bytes_available,
   output logic                 out_valid,
   output u8d_pkg::class_type   out_class
);

   logic                valid_ff;
   u8d_pkg::class_type  class_ff;
   u8d_pkg::class_type  class_in;
   logic [7:0]          cont [u8d_pkg::NUM_CONT];

   assign cont[0] = byte_1;
   assign cont[1] = byte_2;
   assign cont[2] = byte_3;
   assign cont[3] = byte_4;
   assign cont[4] = byte_5;

   always_comb begin
      class_in.empty = (bytes_available == 3'd0);
      class_in.avail = (bytes_available > u8d_pkg::AVAIL_MAX) ? u8d_pkg::AVAIL_MAX
                                                               : bytes_available;
      if (byte_0 >= u8d_pkg::LEAD6_MIN) begin
         class_in.extra        = 3'd5;
         class_in.lead_payload = byte_0 & 8'h01;
      end else if (byte_0 >= u8d_pkg::LEAD5_MIN) begin
         class_in.extra        = 3'd4;
         class_in.lead_payload = byte_0 & 8'h03;
      end else if (byte_0 >= u8d_pkg::LEAD4_MIN) begin
         class_in.extra        = 3'd3;
         class_in.lead_payload = byte_0 & 8'h07;
      end else if (byte_0 >= u8d_pkg::LEAD3_MIN) begin
         class_in.extra        = 3'd2;
         class_in.lead_payload = byte_0 & 8'h0F;
      end else if (byte_0 >= u8d_pkg::LEAD2_MIN) begin
         class_in.extra        = 3'd1;
         class_in.lead_payload = byte_0 & 8'h1F;
      end else begin
         class_in.extra        = 3'd0;
         class_in.lead_payload = byte_0;
      end
      for (int i = 0; i < u8d_pkg::NUM_CONT; i++) begin
         class_in.cont_ok[i]         = ((cont[i] & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_TAG);
         class_in.cont_bits[6*i +: 6] = cont[i][5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      class_ff <= class_in;
   end

   assign out_valid = valid_ff;
   assign out_class = class_ff;

endmodule

/* src/u8d_assemble.sv */
// Second stage of the decoder: checks length and prefixes and packs the
// payload bits into the code point. Depends on u8d_pkg.
module u8d_assemble (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  u8d_pkg::class_type   in_class,
   output logic                 out_valid,
   output u8d_pkg::asm_type     out_asm
);

   logic               valid_ff;
   u8d_pkg::asm_type   asm_ff;
   u8d_pkg::asm_type   asm_in;
   logic [4:0]         need;
   logic [29:0]        c;
   logic [7:0]         p;

   assign c = in_class.cont_bits;
   assign p = in_class.lead_payload;

   always_comb begin
      for (int i = 0; i < u8d_pkg::NUM_CONT; i++) begin
         need[i] = (3'(i) < in_class.extra);
      end
      asm_in.empty = in_class.empty;
      // A sequence that needs more bytes than are available, or a needed byte
      // without the continuation prefix, is an error.
      asm_in.err   = !in_class.empty &&
                     ((in_class.extra >= in_class.avail) || (|(need & ~in_class.cont_ok)));
      asm_in.used  = in_class.extra + 3'd1;
      case (in_class.extra)
         3'd0:    asm_in.value = {23'd0, p};
         3'd1:    asm_in.value = {20'd0, p[4:0], c[5:0]};
         3'd2:    asm_in.value = {15'd0, p[3:0], c[5:0], c[11:6]};
         3'd3:    asm_in.value = {10'd0, p[2:0], c[5:0], c[11:6], c[17:12]};
         3'd4:    asm_in.value = {5'd0, p[1:0], c[5:0], c[11:6], c[17:12], c[23:18]};
         3'd5:    asm_in.value = {p[0], c[5:0], c[11:6], c[17:12], c[23:18], c[29:24]};
         default: asm_in.value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      asm_ff <= asm_in;
   end

   assign out_valid = valid_ff;
   assign out_asm   = asm_ff;

endmodule

/* src/u8d_checker.sv */
// Port-level checker of the UTF-8 sequence decoder, bound to the top level.
// Depends on assert_macros.svh and the ports of utf8_sequence_decoder.
`include "assert_macros.svh"

module u8d_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [30:0] rsp_code_point,
   input logic [2:0]  rsp_bytes_used,
   input logic        rsp_error
);

   // Every accepted beat yields a valid result after passing through the pipeline.
   `ASSERT_DELAYED(a_latency, clock, reset, start && !busy, 3, rsp_valid)

   // An error result carries neither a value nor a length.
   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_valid && rsp_error,
                   rsp_code_point == 31'd0 && rsp_bytes_used == 3'd0)

   // A sequence never consumes more than six bytes.
   `ASSERT_IMPLIES(a_len_max, clock, reset, rsp_valid, rsp_bytes_used <= 3'd6)

   // A one-byte result always fits in eight bits.
   `ASSERT_IMPLIES(a_one_byte, clock, reset, rsp_valid && rsp_bytes_used == 3'd1,
                   rsp_code_point[30:8] == 23'd0)

endmodule

bind utf8_sequence_decoder u8d_checker u_checker (.*);

/* tb/utf8_decode_checker.sv */
`timescale 1ns / 1ps
// Watches the request and response ports of utf8_sequence_decoder, predicts each decoded
// character and compares it field by field. Depends on u8d_pkg.
module utf8_decode_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [7:0]  req_byte_0,
   input  logic [7:0]  req_byte_1,
   input  logic [7:0]  req_byte_2,
   input  logic [7:0]  req_byte_3,
   input  logic [7:0]  req_byte_4,
   input  logic [7:0]  req_byte_5,
   input  logic [2:0]  req_bytes_available,
   input  logic        rsp_valid,
   input  logic [30:0] rsp_code_point,
   input  logic [2:0]  rsp_bytes_used,
   input  logic        rsp_error,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [u8d_pkg::CP_WIDTH-1:0] code_point;
      logic [2:0]                   bytes_used;
      logic                         error;
   } decoded_char_type;

   decoded_char_type expected_chars[$];
   int               failures = 0;

   function automatic decoded_char_type decode_utf8_window(logic [5:0][7:0] win,
                                                           logic [2:0] avail);
      decoded_char_type             d;
      int                           count;
      int                           extra;
      logic [u8d_pkg::CP_WIDTH-1:0] value;
      d = '0;
      value = '0;
      count = (avail > u8d_pkg::AVAIL_MAX) ? u8d_pkg::AVAIL_MAX : avail;
      if (count == 0)
         return d;
      if (win[0] == 8'h00) begin
         d.bytes_used = 3'd1;
         return d;
      end
      if (win[0] >= u8d_pkg::LEAD6_MIN) begin
         extra = 5;
         value[7:0] = win[0] & 8'h01;
      end else if (win[0] >= u8d_pkg::LEAD5_MIN) begin
         extra = 4;
         value[7:0] = win[0] & 8'h03;
      end else if (win[0] >= u8d_pkg::LEAD4_MIN) begin
         extra = 3;
         value[7:0] = win[0] & 8'h07;
      end else if (win[0] >= u8d_pkg::LEAD3_MIN) begin
         extra = 2;
         value[7:0] = win[0] & 8'h0F;
      end else if (win[0] >= u8d_pkg::LEAD2_MIN) begin
         extra = 1;
         value[7:0] = win[0] & 8'h1F;
      end else begin
         extra = 0;
         value[7:0] = win[0];
      end
      if (extra >= count) begin
         d.error = 1'b1;
         return d;
      end
      for (int i = 1; i <= extra; i++) begin
         if ((win[i] & u8d_pkg::CONT_MASK) != u8d_pkg::CONT_TAG) begin
            d.error = 1'b1;
            return d;
         end
         value = {value[u8d_pkg::CP_WIDTH-7:0], win[i][5:0]};
      end
      d.code_point = value;
      d.bytes_used = 3'(extra + 1);
      return d;
   endfunction

   task automatic report_failure(string what);
      failures++;
      if (failures <= 10)
         $display("[%0t] %s", $realtime, what);
   endtask

   always @(posedge clock) begin : watch
      decoded_char_type want;
      if (!reset) begin
         // Compare before pushing, so a beat taken this edge never meets its own result.
         if (rsp_valid) begin
            if (expected_chars.size() == 0) begin
               report_failure($sformatf("unexpected result: cp %h used %0d err %0b",
                                        rsp_code_point, rsp_bytes_used, rsp_error));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_code_point !== want.code_point || rsp_bytes_used !== want.bytes_used
                   || rsp_error !== want.error)
                  report_failure($sformatf(
                     "mismatch: expected cp %h used %0d err %0b, got cp %h used %0d err %0b",
                     want.code_point, want.bytes_used, want.error,
                     rsp_code_point, rsp_bytes_used, rsp_error));
            end
         end
         if (start && !busy)
            expected_chars.push_back(decode_utf8_window(
               {req_byte_5, req_byte_4, req_byte_3, req_byte_2, req_byte_1, req_byte_0},
               req_bytes_available));
      end
      pending    <= expected_chars.size();
      fail_count <= failures;
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the utf8_sequence_decoder test: clock, reset, window stimulus and the verdict.
// Depends on the decoder RTL, u8d_pkg and utf8_decode_checker.
module testbench;

   localparam int RANDOM_WINDOWS = 1425;
   localparam int QUIET_TAIL     = 200;
   localparam int CYCLE_LIMIT    = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_byte_0 = '0;
   logic [7:0]  req_byte_1 = '0;
   logic [7:0]  req_byte_2 = '0;
   logic [7:0]  req_byte_3 = '0;
   logic [7:0]  req_byte_4 = '0;
   logic [7:0]  req_byte_5 = '0;
   logic [2:0]  req_bytes_available = '0;
   logic        rsp_valid;
   logic [30:0] rsp_code_point;
   logic [2:0]  rsp_bytes_used;
   logic        rsp_error;
   int          fail_count;
   int          pending;
   int          cycles = 0;

   always #1 clock = ~clock;

   utf8_sequence_decoder dut (.*);
   utf8_decode_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL utf8_sequence_decoder");
         $finish;
      end
   end

   // Presents one window and holds it until the beat is taken.
   task automatic send_window(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                              logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                              logic [2:0] avail);
      req_byte_0          <= b0;
      req_byte_1          <= b1;
      req_byte_2          <= b2;
      req_byte_3          <= b3;
      req_byte_4          <= b4;
      req_byte_5          <= b5;
      req_bytes_available <= avail;
      start               <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      logic [7:0] w[6];
      int         seq_len;
      int         pick;
      int         idle_pct;
      logic [2:0] avail;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed windows: empty, zero lead, stray continuations, each sequence length
      // from one to six bytes, six-byte leads FE/FF, truncation, bad continuations.
      send_window(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
      send_window(8'h41, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0);
      send_window(8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd1);
      send_window(8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1);
      send_window(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1);
      send_window(8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6);
      send_window(8'hC2, 8'hA9, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2);
      send_window(8'hC0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2);
      send_window(8'hDF, 8'hBF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
      send_window(8'hE2, 8'h82, 8'hAC, 8'h00, 8'h00, 8'h00, 3'd3);
      send_window(8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00, 8'h00, 3'd4);
      send_window(8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h55, 8'hAA, 3'd6);
      send_window(8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'h00, 3'd5);
      send_window(8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00, 3'd5);
      send_window(8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6);
      send_window(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6);
      send_window(8'hFE, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6);
      send_window(8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd7);
      send_window(8'hE2, 8'h82, 8'hAC, 8'h00, 8'h00, 8'h00, 3'd2);
      send_window(8'hFC, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd5);
      send_window(8'hC3, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2);
      send_window(8'hE2, 8'h82, 8'hC0, 8'h00, 8'h00, 8'h00, 3'd3);
      send_window(8'hF0, 8'h9F, 8'h98, 8'h00, 8'h00, 8'h00, 3'd4);
      send_window(8'h41, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd6);
      send_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd6);

      idle_pct = 0;
      for (int n = 0; n < RANDOM_WINDOWS; n++) begin
         // The idle density changes every hundred windows, including runs with none.
         if (n % 100 == 0)
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 10;
               default: idle_pct = 40;
            endcase
         if (n == RANDOM_WINDOWS / 2)
            wait_drained();
         if (n < RANDOM_WINDOWS - QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
            idle_burst();

         for (int i = 0; i < 6; i++)
            w[i] = 8'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            avail = 3'($urandom);
         end else begin
            seq_len = $urandom_range(1, 6);
            case (seq_len)
               1: w[0] = ($urandom_range(0, 3) == 0) ? (8'h80 | 8'($urandom_range(0, 63)))
                                                      : 8'($urandom_range(0, 127));
               2: w[0] = 8'hC0 | 8'($urandom_range(0, 31));
               3: w[0] = 8'hE0 | 8'($urandom_range(0, 15));
               4: w[0] = 8'hF0 | 8'($urandom_range(0, 7));
               5: w[0] = 8'hF8 | 8'($urandom_range(0, 3));
               default: w[0] = 8'hFC | 8'($urandom_range(0, 3));
            endcase
            for (int i = 1; i < seq_len; i++)
               w[i] = 8'h80 | 8'($urandom_range(0, 63));
            if (pick < 30 && seq_len > 1) begin
               avail = 3'($urandom_range(1, seq_len - 1));
            end else begin
               avail = 3'($urandom_range(seq_len, 7));
               // Give one continuation a random prefix of 00, 10 or 11, which breaks it unless 10 is drawn.
               if (pick < 45 && seq_len > 1)
                  w[$urandom_range(1, seq_len - 1)][7:6] = 2'($urandom_range(0, 2)) ^ 2'b10;
            end
         end
         send_window(w[0], w[1], w[2], w[3], w[4], w[5], avail);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS utf8_sequence_decoder");
      end else begin
         $display("FAIL utf8_sequence_decoder");
      end
      $finish;
   end

endmodule
